FILE: design/sorted_key_value_table_top_defines.svh
// assertion macros for the sorted key-value table
`ifndef SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SKVT_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("skvt assertion failed");
`define SKVT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("skvt assertion failed");
`else
`define SKVT_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define SKVT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

FILE: design/skvt_pkg.sv
// shared types and constants of the sorted key-value table
package skvt_pkg;
   localparam int OP_BITS = 2;
   localparam int KEY_FIELD_BITS = 32;
   localparam int VALUE_FIELD_BITS = 32;
   localparam int POS_BITS = 7;

   typedef enum logic [OP_BITS-1:0] {
      OP_SET = 2'd0,
      OP_GET = 2'd1,
      OP_DELETE = 2'd2
   } skvt_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } skvt_state_type;

   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
      logic overwrite;
   } skvt_cell_ctrl_type;
endpackage

FILE: design/skvt_if.sv
// request and response channel interfaces
interface skvt_req_if;
   import skvt_pkg::*;
   logic valid;
   logic ready;
   logic [OP_BITS-1:0] operation;
   logic [KEY_FIELD_BITS-1:0] key;
   logic [VALUE_FIELD_BITS-1:0] value;
   modport source (output valid, output operation, output key, output value, input ready);
   modport sink (input valid, input operation, input key, input value, output ready);
endinterface

interface skvt_rsp_if;
   import skvt_pkg::*;
   logic valid;
   logic ready;
   logic found;
   logic [VALUE_FIELD_BITS-1:0] read_value;
   logic [POS_BITS-1:0] position;
   logic [POS_BITS-1:0] entry_total;
   logic status;
   modport source (output valid, output found, output read_value, output position,
                   output entry_total, output status, input ready);
   modport sink (input valid, input found, input read_value, input position,
                 input entry_total, input status, output ready);
endinterface

FILE: design/sorted_key_value_table_top.sv
// sorted key-value table built as a chain of compare-and-shift cells
//
// req_bus carries operation (set, get, delete), key and value; rsp_bus
// returns found, read_value, position, entry_total and status, one word per
// request word, in order. Both use valid/ready; a word moves when both are high.
// An accepted request is compared against every cell in the next cycle (each
// cell registers key-less-than and key-equal flags), and then, in the apply
// state once the output register is free, the cells shift up for an insert,
// down for a delete or take the new value for an overwrite, while the result
// word is loaded into the output register. A request is not taken before the
// previous one has passed the compare state and then the shift state of the
// cell row, whatever the fill of the table.
// A new request is taken in the shift cycle of the previous one when the
// output register is free or being emptied in that cycle; while the receiver
// holds rsp_bus.ready low with a word waiting, the block parks in the shift
// cycle and stops taking requests. Reset empties the table (entry count zero)
// and drops any pending result; inserting into a full table is refused with
// status set.
module sorted_key_value_table_top #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_BITS = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   skvt_req_if.sink req_bus,
   skvt_rsp_if.source rsp_bus
);
   import skvt_pkg::*;
   `include "sorted_key_value_table_top_defines.svh"

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   skvt_state_type state_ff, state_in;
   logic [OP_BITS-1:0] op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   logic rsp_valid_ff;
   logic rsp_found_ff;
   logic [VALUE_FIELD_BITS-1:0] rsp_read_value_ff;
   logic [POS_BITS-1:0] rsp_position_ff;
   logic [POS_BITS-1:0] rsp_entry_total_ff;
   logic rsp_status_ff;

   logic accept;
   logic fire;
   logic out_free;
   logic is_set, is_delete, is_get;
   logic full;
   skvt_cell_ctrl_type ctrl;

   logic [KEY_BITS-1:0] cell_key [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] cell_value [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_lt;
   logic [TABLE_DEPTH-1:0] cell_eq;

   logic found;
   logic [CNT_W-1:0] position;
   logic [VALUE_BITS-1:0] hit_value;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;
   assign full = count_ff == CNT_W'(TABLE_DEPTH);

   always_comb begin
      is_set = 1'b0;
      is_delete = 1'b0;
      is_get = 1'b0;
      unique case (op_ff)
         OP_SET: is_set = 1'b1;
         OP_DELETE: is_delete = 1'b1;
         default: is_get = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_bus.valid) state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_APPLY;
         ST_APPLY: begin
            if (out_free) begin
               state_in = req_bus.valid ? ST_COMPARE : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_bus.ready = 1'b0;
      fire = 1'b0;
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_COMPARE: ctrl.compare = 1'b1;
         ST_APPLY: begin
            fire = out_free;
            req_bus.ready = out_free;
         end
         default: req_bus.ready = 1'b0;
      endcase
      ctrl.insert = fire && is_set && !found && !full;
      ctrl.remove = fire && is_delete && found;
      ctrl.overwrite = fire && is_set && found;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_bus.operation;
         key_ff <= KEY_BITS'(req_bus.key);
         value_ff <= VALUE_BITS'(req_bus.value);
      end
      if (fire) begin
         rsp_found_ff <= found;
         rsp_read_value_ff <= (is_get && found) ? VALUE_FIELD_BITS'(hit_value) : '0;
         rsp_position_ff <= POS_BITS'(position);
         rsp_entry_total_ff <= POS_BITS'(count_in);
         rsp_status_ff <= is_set && !found && full;
      end
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] left_key, right_key;
      logic [VALUE_BITS-1:0] left_value, right_value;
      logic left_lt;

      if (i == 0) begin : g_first
         assign left_key = key_ff;
         assign left_value = value_ff;
         assign left_lt = 1'b1;
      end else begin : g_inner
         assign left_key = cell_key[i-1];
         assign left_value = cell_value[i-1];
         assign left_lt = cell_lt[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_key = cell_key[i];
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_key = cell_key[i+1];
         assign right_value = cell_value[i+1];
      end

      skvt_cell #(
         .KEY_BITS(KEY_BITS),
         .VALUE_BITS(VALUE_BITS),
         .CNT_W(CNT_W),
         .INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .entry_count(count_ff),
         .new_key(key_ff),
         .new_value(value_ff),
         .left_key(left_key),
         .left_value(left_value),
         .right_key(right_key),
         .right_value(right_value),
         .left_lt(left_lt),
         .key(cell_key[i]),
         .value(cell_value[i]),
         .lt(cell_lt[i]),
         .eq(cell_eq[i])
      );
   end

   skvt_gather #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .VALUE_BITS(VALUE_BITS),
      .CNT_W(CNT_W)
   ) u_gather (
      .cell_lt(cell_lt),
      .cell_eq(cell_eq),
      .cell_value(cell_value),
      .found(found),
      .position(position),
      .read_value(hit_value)
   );

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.found = rsp_found_ff;
   assign rsp_bus.read_value = rsp_read_value_ff;
   assign rsp_bus.position = rsp_position_ff;
   assign rsp_bus.entry_total = rsp_entry_total_ff;
   assign rsp_bus.status = rsp_status_ff;

   `SKVT_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `SKVT_ASSERT_IMPLIES(a_single_match, clock, reset, state_ff == ST_APPLY, $onehot0(cell_eq))
   `SKVT_ASSERT_NEXT(a_count_hold, clock, reset, !fire, $stable(count_ff))
   `SKVT_ASSERT_IMPLIES(a_refused_absent, clock, reset, rsp_valid_ff && rsp_status_ff, !rsp_found_ff)
endmodule

FILE: design/skvt_cell.sv
// one table slot: holds a key and value, compares and shifts with its neighbors
module skvt_cell #(
   parameter int KEY_BITS = 32,
   parameter int VALUE_BITS = 32,
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic clock,
   input  logic reset,
   input  skvt_pkg::skvt_cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0] entry_count,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [VALUE_BITS-1:0] new_value,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [VALUE_BITS-1:0] right_value,
   input  logic left_lt,
   output logic [KEY_BITS-1:0] key,
   output logic [VALUE_BITS-1:0] value,
   output logic lt,
   output logic eq
);
   import skvt_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic lt_ff, eq_ff;
   logic occupied;

   assign occupied = CNT_W'(INDEX) < entry_count;

   always_comb begin
      key_in = key_ff;
      value_in = value_ff;
      if (ctrl.insert && !lt_ff) begin
         if (left_lt) begin
            key_in = new_key;
            value_in = new_value;
         end else begin
            key_in = left_key;
            value_in = left_value;
         end
      end else if (ctrl.remove && !lt_ff) begin
         key_in = right_key;
         value_in = right_value;
      end else if (ctrl.overwrite && eq_ff) begin
         value_in = new_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else if (ctrl.compare) begin
         lt_ff <= occupied && (key_ff < new_key);
         eq_ff <= occupied && (key_ff == new_key);
      end
   end

   assign key = key_ff;
   assign value = value_ff;
   assign lt = lt_ff;
   assign eq = eq_ff;
endmodule

FILE: design/skvt_gather.sv
// collects the cell flags into found, lower-bound position and read value
module skvt_gather #(
   parameter int TABLE_DEPTH = 64,
   parameter int VALUE_BITS = 32,
   parameter int CNT_W = 7
) (
   input  logic [TABLE_DEPTH-1:0] cell_lt,
   input  logic [TABLE_DEPTH-1:0] cell_eq,
   input  logic [VALUE_BITS-1:0] cell_value [TABLE_DEPTH],
   output logic found,
   output logic [CNT_W-1:0] position,
   output logic [VALUE_BITS-1:0] read_value
);
   import skvt_pkg::*;

   logic [TABLE_DEPTH:0] boundary;

   always_comb begin
      boundary[0] = !cell_lt[0];
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         boundary[i] = cell_lt[i-1] && !cell_lt[i];
      end
      boundary[TABLE_DEPTH] = cell_lt[TABLE_DEPTH-1];
   end

   always_comb begin
      position = '0;
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         position = position | (boundary[i] ? CNT_W'(i) : '0);
      end
   end

   always_comb begin
      read_value = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         read_value = read_value | (cell_eq[i] ? cell_value[i] : '0);
      end
   end

   assign found = |cell_eq;
endmodule
